// File: hw/rtl/kpbe_pkg.sv
// ----------------------------------------------------------------------------
// kpbe_pkg
// Shared types, register indexes, reset values and helpers of the pitch and
// gyro bias estimator.
// ----------------------------------------------------------------------------
package kpbe_pkg;

  typedef struct packed {
    logic signed [31:0] gyro_rate_x;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [23:0]        time_step;
  } kpbe_in_t;

  typedef struct packed {
    logic signed [31:0] pitch;
    logic signed [31:0] pitch_rate;
  } kpbe_out_t;

  localparam int REG_W = 47;
  localparam int MOP_W = 52;

  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd1;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

  localparam logic [REG_W-1:0] ANGLE_NOISE_RST   = 47'd109951163;
  localparam logic [REG_W-1:0] BIAS_NOISE_RST    = 47'd10995116;
  localparam logic [REG_W-1:0] MEASURE_NOISE_RST = 47'd32985348833;
  localparam logic signed [47:0] COV_RST         = 48'sd1099511628;

  // Arctangents of 2^-i with 30 fractional bits, truncated.
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000};

  function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
    logic signed [31:0] r;
    if (v > 53'sh7FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -53'sh80000000) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [52:0] v);
    logic signed [47:0] r;
    if (v > 53'sh7FFFFFFFFFFF) r = 48'sh7FFFFFFFFFFF;
    else if (v < -53'sh800000000000) r = 48'sh800000000000;
    else r = 48'(v);
    return r;
  endfunction

endpackage

// File: hw/rtl/kalman_pitch_bias_estimator_unit.sv
// ----------------------------------------------------------------------------
// kalman_pitch_bias_estimator_unit
// Two-state Kalman filter for pitch angle and gyro bias, one IMU item in and
// one pitch and rate item out, run on a shared multiplier and divider.
// ----------------------------------------------------------------------------
// Most of the time for an item is spent in the gain divider, which produces
// one quotient bit per cycle for each of the two gains; the ten products run
// on the shared 13-bit-per-cycle multiplier. The accelerometer CORDIC runs
// alongside the prediction products. in_ready is high only while no item is
// in progress, so the next item can be accepted in the cycle after the
// result is registered; a finished result waits in the output register while
// the next item is accepted, and a new result waits for that register to
// empty. Noise registers may be written through the cfg port while idle.
module kalman_pitch_bias_estimator_unit import kpbe_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  kpbe_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output kpbe_out_t        out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [REG_W-1:0] cfg_wdata
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MGO   = 7'b0000010,
    ST_MWAIT = 7'b0000100,
    ST_CWAIT = 7'b0001000,
    ST_DGO   = 7'b0010000,
    ST_DWAIT = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    OP_ANG, OP_DTBB, OP_PAA, OP_PBB, OP_K0, OP_K1,
    OP_UANG, OP_UBIAS, OP_UBA, OP_UBB, OP_UAA, OP_UAB
  } op_t;

  state_t st_r;
  op_t op_r;
  kpbe_in_t item_r;
  logic [REG_W-1:0] an_r, bn_r, mn_r;
  logic signed [31:0] angle_r, bias_r, rate_r;
  logic signed [47:0] paa_r, pab_r, pba_r, pbb_r, dtbb_r, k0_r, k1_r;
  logic signed [32:0] innov_r;
  logic signed [49:0] sv_r;
  logic out_valid_r;
  kpbe_out_t out_data_r;

  logic accept;
  logic signed [MOP_W-1:0] dt_op, inner, mop_a, mop_b;
  logic m_frac40, m_done, d_done, c_done;
  logic signed [47:0] m_prod, d_quo, d_num;
  logic signed [31:0] c_meas;

  assign in_ready = (st_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign dt_op    = MOP_W'($signed({1'b0, item_r.time_step}));
  assign inner    = MOP_W'(dtbb_r) - MOP_W'(pab_r) - MOP_W'(pba_r)
                  + MOP_W'($signed({1'b0, an_r}));
  assign d_num    = (op_r == OP_K0) ? paa_r : pba_r;

  always_comb begin
    mop_a    = '0;
    mop_b    = '0;
    m_frac40 = 1'b1;
    unique case (op_r)
      OP_ANG: begin
        mop_a = MOP_W'(rate_r); mop_b = dt_op; m_frac40 = 1'b0;
      end
      OP_DTBB: begin
        mop_a = dt_op; mop_b = MOP_W'(pbb_r); m_frac40 = 1'b0;
      end
      OP_PAA: begin
        mop_a = dt_op; mop_b = inner; m_frac40 = 1'b0;
      end
      OP_PBB: begin
        mop_a = MOP_W'($signed({1'b0, bn_r})); mop_b = dt_op; m_frac40 = 1'b0;
      end
      OP_UANG:  begin mop_a = MOP_W'(k0_r); mop_b = MOP_W'(innov_r); end
      OP_UBIAS: begin mop_a = MOP_W'(k1_r); mop_b = MOP_W'(innov_r); end
      OP_UBA:   begin mop_a = MOP_W'(k1_r); mop_b = MOP_W'(paa_r); end
      OP_UBB:   begin mop_a = MOP_W'(k1_r); mop_b = MOP_W'(pab_r); end
      OP_UAA:   begin mop_a = MOP_W'(k0_r); mop_b = MOP_W'(paa_r); end
      OP_UAB:   begin mop_a = MOP_W'(k0_r); mop_b = MOP_W'(pab_r); end
      default: ;
    endcase
  end

  kpbe_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (st_r == ST_MGO),
    .op_a   (mop_a),
    .op_b   (mop_b),
    .frac40 (m_frac40),
    .done   (m_done),
    .prod   (m_prod)
  );

  kpbe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == ST_DGO),
    .num   (d_num),
    .den   (sv_r),
    .done  (d_done),
    .quo   (d_quo)
  );

  kpbe_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .accel_x (in_data.accel_x),
    .accel_y (in_data.accel_y),
    .accel_z (in_data.accel_z),
    .done    (c_done),
    .meas    (c_meas)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      an_r <= ANGLE_NOISE_RST;
      bn_r <= BIAS_NOISE_RST;
      mn_r <= MEASURE_NOISE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ANGLE_NOISE:   an_r <= cfg_wdata;
        REG_BIAS_NOISE:    bn_r <= cfg_wdata;
        REG_MEASURE_NOISE: mn_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      op_r        <= OP_ANG;
      out_valid_r <= 1'b0;
      angle_r     <= '0;
      bias_r      <= '0;
      paa_r       <= COV_RST;
      pab_r       <= '0;
      pba_r       <= '0;
      pbb_r       <= COV_RST;
    end else begin
      if (out_valid_r && out_ready && st_r != ST_DONE) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (accept) begin
            item_r <= in_data;
            rate_r <= sat32(53'(in_data.gyro_rate_x) - 53'(bias_r));
            op_r   <= OP_ANG;
            st_r   <= ST_MGO;
          end
        end
        ST_MGO: st_r <= ST_MWAIT;
        ST_MWAIT: begin
          if (m_done) begin
            unique case (op_r)
              OP_ANG: begin
                angle_r <= sat32(53'(angle_r) + 53'(m_prod));
                op_r    <= OP_DTBB;
                st_r    <= ST_MGO;
              end
              OP_DTBB: begin
                dtbb_r <= m_prod;
                op_r   <= OP_PAA;
                st_r   <= ST_MGO;
              end
              OP_PAA: begin
                paa_r <= sat48(53'(paa_r) + 53'(m_prod));
                pab_r <= sat48(53'(pab_r) - 53'(dtbb_r));
                pba_r <= sat48(53'(pba_r) - 53'(dtbb_r));
                op_r  <= OP_PBB;
                st_r  <= ST_MGO;
              end
              OP_PBB: begin
                pbb_r <= sat48(53'(pbb_r) + 53'(m_prod));
                st_r  <= ST_CWAIT;
              end
              OP_UANG: begin
                angle_r <= sat32(53'(angle_r) + 53'(m_prod));
                op_r    <= OP_UBIAS;
                st_r    <= ST_MGO;
              end
              OP_UBIAS: begin
                bias_r <= sat32(53'(bias_r) + 53'(m_prod));
                op_r   <= OP_UBA;
                st_r   <= ST_MGO;
              end
              // The bias row goes first so both rows see the old paa and pab.
              OP_UBA: begin
                pba_r <= sat48(53'(pba_r) - 53'(m_prod));
                op_r  <= OP_UBB;
                st_r  <= ST_MGO;
              end
              OP_UBB: begin
                pbb_r <= sat48(53'(pbb_r) - 53'(m_prod));
                op_r  <= OP_UAA;
                st_r  <= ST_MGO;
              end
              OP_UAA: begin
                paa_r <= sat48(53'(paa_r) - 53'(m_prod));
                op_r  <= OP_UAB;
                st_r  <= ST_MGO;
              end
              OP_UAB: begin
                pab_r <= sat48(53'(pab_r) - 53'(m_prod));
                st_r  <= ST_DONE;
              end
              default: st_r <= ST_IDLE;
            endcase
          end
        end
        ST_CWAIT: begin
          if (c_done) begin
            innov_r <= 33'(c_meas) - 33'(angle_r);
            sv_r    <= 50'(paa_r) + 50'($signed({1'b0, mn_r}));
            op_r    <= OP_K0;
            st_r    <= ST_DGO;
          end
        end
        ST_DGO: st_r <= ST_DWAIT;
        ST_DWAIT: begin
          if (d_done) begin
            if (op_r == OP_K0) begin
              k0_r <= d_quo;
              op_r <= OP_K1;
              st_r <= ST_DGO;
            end else begin
              k1_r <= d_quo;
              op_r <= OP_UANG;
              st_r <= ST_MGO;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.pitch      <= angle_r;
            out_data_r.pitch_rate <= sat32(53'(rate_r) + 53'(bias_r));
            out_valid_r           <= 1'b1;
            st_r                  <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/kpbe_mul.sv
// ----------------------------------------------------------------------------
// kpbe_mul
// Shared sign-magnitude multiplier: 13 bits of the second operand per cycle,
// then round to nearest (ties away from zero), shift and saturate to 48 bit.
// ----------------------------------------------------------------------------
module kpbe_mul import kpbe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [MOP_W-1:0] op_a,
  input  logic signed [MOP_W-1:0] op_b,
  input  logic                    frac40,
  output logic                    done,
  output logic signed [47:0]      prod
);

  localparam int CH    = 13;
  localparam int NCH   = MOP_W / CH;
  localparam int ACC_W = 2 * MOP_W;
  localparam int CW    = $clog2(NCH);

  typedef enum logic [2:0] {
    MS_IDLE = 3'b001,
    MS_RUN  = 3'b010,
    MS_RND  = 3'b100
  } mstate_t;

  mstate_t st_r, st_nxt;
  logic [MOP_W-1:0] ua_r, ub_r;
  logic neg_r, f40_r, done_r;
  logic [ACC_W-1:0] acc_r;
  logic [CW-1:0] cnt_r;
  logic signed [47:0] prod_r;

  logic [MOP_W+CH-1:0] partial;
  logic [ACC_W-1:0] acc_nxt, sum, quo;
  logic [47:0] lim, qs;

  assign partial = ua_r * ub_r[MOP_W-1 -: CH];
  assign acc_nxt = (acc_r << CH) + ACC_W'(partial);
  assign sum = acc_r + (f40_r ? (ACC_W'(1) << 39) : (ACC_W'(1) << 23));
  assign quo = f40_r ? (sum >> 40) : (sum >> 24);
  assign lim = neg_r ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
  assign qs  = (quo > ACC_W'(lim)) ? lim : quo[47:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      MS_IDLE: if (start) st_nxt = MS_RUN;
      MS_RUN:  if (cnt_r == CW'(NCH - 1)) st_nxt = MS_RND;
      MS_RND:  st_nxt = MS_IDLE;
      default: st_nxt = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == MS_RND);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == MS_IDLE && start) begin
      ua_r  <= op_a[MOP_W-1] ? MOP_W'(-op_a) : MOP_W'(op_a);
      ub_r  <= op_b[MOP_W-1] ? MOP_W'(-op_b) : MOP_W'(op_b);
      neg_r <= op_a[MOP_W-1] ^ op_b[MOP_W-1];
      f40_r <= frac40;
      acc_r <= '0;
      cnt_r <= '0;
    end else if (st_r == MS_RUN) begin
      acc_r <= acc_nxt;
      ub_r  <= ub_r << CH;
      cnt_r <= cnt_r + 1'b1;
    end
    if (st_r == MS_RND) prod_r <= neg_r ? -$signed(qs) : $signed(qs);
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// File: hw/rtl/kpbe_div.sv
// ----------------------------------------------------------------------------
// kpbe_div
// Restoring divider for the gains: num * 2^40 / den, one quotient bit per
// cycle, truncated toward zero and saturated to signed 48 bit.
// ----------------------------------------------------------------------------
module kpbe_div import kpbe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [47:0] num,
  input  logic signed [49:0] den,
  output logic               done,
  output logic signed [47:0] quo
);

  localparam int DVD_W = 88;
  localparam int CNT_W = $clog2(DVD_W);

  typedef enum logic [2:0] {
    DS_IDLE = 3'b001,
    DS_RUN  = 3'b010,
    DS_FIN  = 3'b100
  } dstate_t;

  dstate_t st_r, st_nxt;
  logic neg_r, done_r;
  logic [48:0] ud_r, rem_r, q_r;
  logic [DVD_W-1:0] dvd_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [47:0] quo_r;

  logic [49:0] r2, rsub, q2;
  logic ge;
  logic [47:0] un;
  logic [49:0] udm;
  logic [47:0] lim, qs;

  assign un  = num[47] ? 48'(-num) : 48'(num);
  assign udm = den[49] ? 50'(-den) : 50'(den);
  assign r2   = {rem_r, dvd_r[DVD_W-1]};
  assign ge   = r2 >= {1'b0, ud_r};
  assign rsub = r2 - {1'b0, ud_r};
  assign q2   = {q_r, ge};
  assign lim  = neg_r ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
  assign qs   = (q_r > {1'b0, lim}) ? lim : q_r[47:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      DS_IDLE: if (start) st_nxt = DS_RUN;
      DS_RUN:  if (cnt_r == CNT_W'(DVD_W - 1)) st_nxt = DS_FIN;
      DS_FIN:  st_nxt = DS_IDLE;
      default: st_nxt = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == DS_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == DS_IDLE && start) begin
      neg_r <= num[47] ^ den[49];
      ud_r  <= udm[48:0];
      dvd_r <= {un, 40'b0};
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= '0;
    end else if (st_r == DS_RUN) begin
      rem_r <= ge ? rsub[48:0] : r2[48:0];
      // The quotient sticks at 2^48 once it passes it; the final clamp is lower.
      q_r   <= (q2 > 50'h1000000000000) ? 49'h1000000000000 : q2[48:0];
      dvd_r <= dvd_r << 1;
      cnt_r <= cnt_r + 1'b1;
    end
    if (st_r == DS_FIN) begin
      if (ud_r == '0) quo_r <= '0;
      else quo_r <= neg_r ? -$signed(qs) : $signed(qs);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: hw/rtl/kpbe_cordic.sv
// ----------------------------------------------------------------------------
// kpbe_cordic
// Accelerometer pitch: sum of squares, bit-pair square root and a vectoring
// CORDIC giving atan2(-accel_x, sqrt(accel_y^2 + accel_z^2)) in Q16.16.
// ----------------------------------------------------------------------------
module kpbe_cordic import kpbe_pkg::*; #(
  parameter int STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               done,
  output logic signed [31:0] meas
);

  localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [5:0] {
    CS_IDLE = 6'b000001,
    CS_SQA  = 6'b000010,
    CS_SQB  = 6'b000100,
    CS_ROOT = 6'b001000,
    CS_ROT  = 6'b010000,
    CS_FIN  = 6'b100000
  } cstate_t;

  cstate_t st_r, st_nxt;
  logic done_r, zero_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic [31:0] sq_r;
  logic [47:0] v_r, res_r, bit_r;
  logic signed [27:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic [CW-1:0] cnt_r;
  logic signed [31:0] meas_r;

  logic signed [31:0] prod;
  logic [47:0] t, res_nxt;
  logic fits;
  logic signed [27:0] dx, dy;
  logic signed [33:0] at, zr;

  assign prod    = (st_r == CS_SQA) ? ay_r * ay_r : az_r * az_r;
  assign t       = res_r + bit_r;
  assign fits    = v_r >= t;
  assign res_nxt = fits ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  assign dx      = y_r >>> cnt_r;
  assign dy      = x_r >>> cnt_r;
  assign at      = $signed({2'b00, ATAN_TAB[5'(cnt_r)]});
  assign zr      = (z_r + 34'sd8192) >>> 14;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      CS_IDLE: if (start) st_nxt = CS_SQA;
      CS_SQA:  st_nxt = CS_SQB;
      CS_SQB:  st_nxt = CS_ROOT;
      CS_ROOT: if (bit_r[0]) st_nxt = CS_ROT;
      CS_ROT:  if (cnt_r == CW'(STEPS - 1)) st_nxt = CS_FIN;
      CS_FIN:  st_nxt = CS_IDLE;
      default: st_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= CS_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == CS_IDLE && start) done_r <= 1'b0;
      else if (st_r == CS_FIN) done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      CS_IDLE: begin
        ax_r <= accel_x;
        ay_r <= accel_y;
        az_r <= accel_z;
      end
      CS_SQA: sq_r <= 32'(prod);
      CS_SQB: begin
        v_r   <= {sq_r + 32'(prod), 16'b0};
        res_r <= '0;
        bit_r <= 48'h1 << 46;
      end
      CS_ROOT: begin
        if (fits) v_r <= v_r - t;
        res_r <= res_nxt;
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          x_r    <= 28'(res_nxt);
          y_r    <= -($signed({{12{ax_r[15]}}, ax_r}) <<< 8);
          z_r    <= '0;
          cnt_r  <= '0;
          zero_r <= (res_nxt == '0) && (ax_r == '0);
        end
      end
      CS_ROT: begin
        // Rotate toward y = 0; a positive y turns the vector down.
        if (y_r > 0) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      CS_FIN: meas_r <= zero_r ? '0 : 32'(zr);
      default: ;
    endcase
  end

  assign done = done_r;
  assign meas = meas_r;

endmodule
